// ----- src/integer_to_radix_ascii_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the integer to radix text converter
// Shared shorthand for the concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ITORA_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define ITORA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/itora_pkg.sv -----
// ----------------------------------------------------------------------------
// itora_pkg
// Types, constants, microcode and the digit glyph function of the converter.
// ----------------------------------------------------------------------------
package itora_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF = 32;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned PC_W    = 3;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [APB_AW-1:0]  REG_RADIX_ADDR = 3'd0;
  localparam logic [RADIX_W-1:0] RADIX_RESET    = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL  = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_Z     = 7'd90;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_STORE,
    OP_SIGN,
    OP_POP,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_INPUT,
    WAIT_DIV,
    WAIT_OUT
  } wait_e;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_QUOT_NZ,
    JMP_COUNT_NZ
  } jcond_e;

  typedef struct packed {
    op_e              op;
    wait_e            wait_on;
    jcond_e           jcond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic out_free;
    logic quot_nz;
    logic count_nz;
  } status_t;

  // Sequencer command to the datapath.
  typedef struct packed {
    op_e  op;
    logic fire;
  } cmd_t;

  // Program: load, divide per digit, emit sign, pop and emit digits.
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, wait_on: WAIT_NONE, jcond: JMP_ALWAYS, target: 3'd0};
    unique case (pc)
      3'd0: w = '{op: OP_LOAD,      wait_on: WAIT_INPUT, jcond: JMP_NEVER,    target: 3'd0};
      3'd1: w = '{op: OP_DIV_START, wait_on: WAIT_NONE,  jcond: JMP_NEVER,    target: 3'd0};
      3'd2: w = '{op: OP_STORE,     wait_on: WAIT_DIV,   jcond: JMP_QUOT_NZ,  target: 3'd1};
      3'd3: w = '{op: OP_SIGN,      wait_on: WAIT_OUT,   jcond: JMP_NEVER,    target: 3'd0};
      3'd4: w = '{op: OP_POP,       wait_on: WAIT_NONE,  jcond: JMP_NEVER,    target: 3'd0};
      3'd5: w = '{op: OP_EMIT,      wait_on: WAIT_OUT,   jcond: JMP_COUNT_NZ, target: 3'd4};
      3'd6: w = '{op: OP_NOP,       wait_on: WAIT_NONE,  jcond: JMP_ALWAYS,   target: 3'd0};
      default: w = '{op: OP_NOP, wait_on: WAIT_NONE, jcond: JMP_ALWAYS, target: 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph(logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < RADIX_DECIMAL) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - RADIX_DECIMAL);
    end
    return c;
  endfunction

endpackage

// ----- src/itora_divider.sv -----
// ----------------------------------------------------------------------------
// itora_divider
// Restoring serial divider, one quotient bit per cycle, by a 6-bit radix.
// ----------------------------------------------------------------------------
module itora_divider import itora_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [RADIX_W-1:0]    rem_o
);

  localparam int unsigned CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q, div_d;
  logic [RADIX_W:0]      trial;
  logic                  ge;

  // The partial remainder stays below the divisor, so it fits in six bits.
  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_BITS-2:0], ge};
      rem_d  = ge ? RADIX_W'(trial - {1'b0, div_q}) : trial[RADIX_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LAST_BIT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/itora_stack.sv -----
// ----------------------------------------------------------------------------
// itora_stack
// Digit memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module itora_stack import itora_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(MAX_DIGITS)-1:0] waddr_i,
  input  logic [RADIX_W-1:0]            wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(MAX_DIGITS)-1:0] raddr_i,
  output logic [RADIX_W-1:0]            rdata_o
);

  logic [RADIX_W-1:0] mem_q [MAX_DIGITS];
  logic [RADIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/itora_sequencer.sv -----
// ----------------------------------------------------------------------------
// itora_sequencer
// Step counter over the microcode table, with wait and jump conditions.
// ----------------------------------------------------------------------------
module itora_sequencer import itora_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            fire;
  logic            jump;

  assign uw = ucode(pc_q);

  always_comb begin
    unique case (uw.wait_on)
      WAIT_NONE:  fire = 1'b1;
      WAIT_INPUT: fire = status_i.in_valid;
      WAIT_DIV:   fire = status_i.div_done;
      WAIT_OUT:   fire = status_i.out_free;
      default:    fire = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.jcond)
      JMP_NEVER:    jump = 1'b0;
      JMP_ALWAYS:   jump = 1'b1;
      JMP_QUOT_NZ:  jump = status_i.quot_nz;
      JMP_COUNT_NZ: jump = status_i.count_nz;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      pc_d = jump ? uw.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign cmd_o = '{op: uw.op, fire: fire};

endmodule

// ----- src/integer_to_radix_ascii.sv -----
// Steps: load the value, one serial division per digit, the sign, then a pop and
// an emit per character while the output is taken, and a return to the load step.
// One number is in work at a time; the next is taken once its last character
// has entered the output register and the sequencer has passed its return step.
// Reset is asynchronous, active low: the radix returns to ten, step counter and
// valid clear.
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Microcoded converter of an integer (signed in decimal, unsigned in other radices) to its ASCII text in a radix 2..36.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii import itora_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // value
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // character, then zero fill
  output logic [7:0]                          m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [APB_AW-1:0]                   paddr,
  input  logic [APB_DW-1:0]                   pwdata,
  output logic [APB_DW-1:0]                   prdata,
  output logic                                pready
);

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] LIMIT_POS = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] LIMIT_NEG = CNT_W'(MAX_DIGITS - 1);

  logic [RADIX_W-1:0]    radix_q;
  logic [RADIX_W-1:0]    radix_eff;
  logic [VALUE_BITS-1:0] value;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      count_dec;
  logic [CNT_W-1:0]      limit;

  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  out_free;
  logic                  out_load;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  logic                  st_we;
  logic                  st_re;
  logic [RADIX_W-1:0]    st_rdata;

  status_t               status;
  cmd_t                  cmd;
  logic                  cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_RADIX_ADDR);
  assign prdata = (paddr == REG_RADIX_ADDR) ? APB_DW'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_wr) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  // Out-of-range radix settings saturate to the nearest legal base.
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_q;
    end
  end

  assign value  = s_axis_tdata[VALUE_BITS-1:0];
  assign in_neg = (radix_eff == RADIX_DECIMAL) && value[VALUE_BITS-1];
  assign in_mag = in_neg ? ({VALUE_BITS{1'b0}} - value) : value;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign limit     = neg_q ? LIMIT_NEG : LIMIT_POS;
  assign count_dec = count_q - 1'b1;

  assign status = '{
    in_valid: s_axis_tvalid,
    div_done: div_done,
    out_free: out_free,
    quot_nz:  |div_quot,
    count_nz: count_q != '0
  };

  itora_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  itora_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (radix_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  itora_stack #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (div_rem),
    .re_i    (st_re),
    .raddr_i (count_dec[IDX_W-1:0]),
    .rdata_o (st_rdata)
  );

  // Datapath decode of the current control word.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    st_we         = 1'b0;
    st_re         = 1'b0;
    out_load      = 1'b0;
    out_char_d    = out_char_q;
    out_last_d    = out_last_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    count_d       = count_q;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        s_axis_tready = 1'b1;
        if (cmd.fire) begin
          mag_d   = in_mag;
          neg_d   = in_neg;
          count_d = '0;
        end
      end
      OP_DIV_START: begin
        div_start = cmd.fire;
      end
      OP_STORE: begin
        if (cmd.fire) begin
          mag_d = div_quot;
          // Digits beyond the result limit are dropped, most significant first.
          if (count_q < limit) begin
            st_we   = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      OP_SIGN: begin
        if (cmd.fire && neg_q) begin
          out_load   = 1'b1;
          out_char_d = ASCII_MINUS;
          out_last_d = 1'b0;
        end
      end
      OP_POP: begin
        if (cmd.fire) begin
          st_re   = 1'b1;
          count_d = count_dec;
        end
      end
      OP_EMIT: begin
        if (cmd.fire) begin
          out_load   = 1'b1;
          out_char_d = glyph(st_rdata);
          out_last_d = (count_q == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      neg_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- src/itora_checker.sv -----
// ----------------------------------------------------------------------------
// itora_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_radix_ascii_macros.svh"

module itora_checker import itora_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready
);

  logic [CHAR_W-1:0] ch;
  logic [9:0]        out_word;
  logic              out_stall;
  logic              char_ok;
  logic              sign_out;
  logic              in_take;

  assign ch        = m_axis_tdata[CHAR_W-1:0];
  assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign char_ok   = (ch == ASCII_MINUS) || (ch >= ASCII_ZERO && ch <= ASCII_NINE) ||
                     (ch >= ASCII_A && ch <= ASCII_Z);
  assign sign_out  = m_axis_tvalid && (ch == ASCII_MINUS);
  assign in_take   = s_axis_tvalid && s_axis_tready;

  // A stalled output word keeps its valid, its character and its last mark.
  `ITORA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_word), "stalled word changed")

  // Every character is a minus sign, a digit or an upper-case letter.
  `ITORA_ASSERT_HOLDS(a_char_legal, clk_i, rst_ni, !m_axis_tvalid || char_ok, "illegal character")

  // The sign always precedes at least one digit.
  `ITORA_ASSERT_HOLDS(a_sign_not_last, clk_i, rst_ni, !sign_out || !m_axis_tlast, "sign marked last")

  // Once a number is taken, the converter is busy and not ready in the cycle after.
  `ITORA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_take, !s_axis_tready, "input taken twice")

endmodule

bind integer_to_radix_ascii itora_checker u_itora_checker (.*);

// ----- bench/integer_to_radix_ascii_test.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_test
// Streams signed integers into the converter under several radix settings
// and checks every returned character and its last mark against a predictor
// kept in the bench. Both stream sides stall in random bursts, and the radix
// register is written and read back over APB between batches.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_test;
  import itora_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 1200;
  // An address past the register list; writes there must be dropped.
  localparam logic [APB_AW-1:0] UNUSED_ADDR = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [31:0]       s_axis_tdata = '0;   // value
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        m_axis_tdata;        // character, then zero fill
  logic              m_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic [31:0]       value_queue[$];
  text_char_t        expected_text[$];
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;
  bit                calm = 1'b0;
  int unsigned       hold_ordered = 0;
  int unsigned       hold_served = 0;
  int unsigned       gap_left = 0;
  int unsigned       stall_left = 0;
  int unsigned       mismatches = 0;
  int unsigned       config_errors = 0;
  int unsigned       cycle_count = 0;

  integer_to_radix_ascii dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Spells one value in the given radix setting and queues its characters.
  function automatic void spell_number(input logic [31:0] v, input logic [RADIX_W-1:0] setting);
    int unsigned  base;
    logic [31:0]  mag;
    logic [5:0]   digits[$];
    bit           minus;
    text_char_t   c;
    base = (setting < RADIX_MIN) ? RADIX_MIN : (setting > RADIX_MAX) ? RADIX_MAX : setting;
    minus = (base == RADIX_DECIMAL) && v[31];
    mag = minus ? 32'd0 - v : v;
    // At 32 bits no text can exceed the digit store, so nothing is dropped.
    do begin
      digits.push_back(6'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (minus) begin
      c.code = ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      if (digits[i] < RADIX_DECIMAL) begin
        c.code = ASCII_ZERO + CHAR_W'(digits[i]);
      end else begin
        c.code = ASCII_A + CHAR_W'(digits[i] - RADIX_DECIMAL);
      end
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // Mix of full-range values, small ones, extremes and radix powers.
  function automatic logic [31:0] pick_value(input int unsigned base);
    logic [31:0]     v;
    longint unsigned p;
    p = 1;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 100);
      2: v = 32'd0 - $urandom_range(1, 1000);
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'd1;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      4: begin
        repeat ($urandom_range(1, 31)) begin
          if (p * base <= 64'hFFFF_FFFF) p = p * base;
        end
        v = p[31:0] + $urandom_range(0, 2) - 1;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (write && addr == REG_RADIX_ADDR) radix_now = data[RADIX_W-1:0];
  endtask

  task automatic check_radix_readback;
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, REG_RADIX_ADDR, '0, rd);
    if (rd !== APB_DW'(radix_now)) begin
      $error("radix: expected %0d, got %0d", radix_now, rd);
      config_errors++;
    end
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] setting);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, REG_RADIX_ADDR, APB_DW'(setting), rd);
    check_radix_readback();
  endtask

  // Waits until every queued value is taken and every character is back.
  // The check runs between edges, where the sender's and receiver's updates have settled.
  task automatic drain;
    @(negedge clk_i);
    while (value_queue.size() != 0 || s_axis_tvalid || expected_text.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // Sender: offers queued values, pausing in random bursts between them unless calm is set.
  always @(posedge clk_i or negedge rst_ni) begin : feed_side
    logic        next_valid;
    logic [31:0] next_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      <= 0;
    end else begin
      next_valid = s_axis_tvalid;
      next_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        spell_number(s_axis_tdata, radix_now);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (value_queue.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 11);
          end else begin
            next_data  = value_queue.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_data;
    end
  end

  // Receiver: checks each word against the oldest expected character.
  always @(posedge clk_i or negedge rst_ni) begin : take_side
    text_char_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected word: character %0d, last %0d", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata !== {1'b0, want.code}) begin
            $error("character: expected %0d, got %0d", want.code, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (hold_ordered != hold_served) begin
        hold_served   <= hold_served + 1;
        stall_left    <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left    <= $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_to_radix_ascii regression: fail");
      $finish;
    end
  end

  initial begin : sequence_main
    logic [RADIX_W-1:0] phase_radix[12];
    logic [RADIX_W-1:0] r;
    logic [APB_DW-1:0]  rd;
    int unsigned        base;
    int unsigned        count;
    phase_radix = '{6'd10, 6'd2, 6'd36, 6'd1, 6'd37, 6'd16, 6'd8, 6'd63, 6'd3, 6'd0,
                    6'd10, 6'd36};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Decimal at the reset radix: zero, signs, both extremes.
    check_radix_readback();
    value_queue = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'd1234567890};
    drain();
    // Radix zero saturates to two; negative values read as unsigned.
    set_radix(6'd0);
    value_queue = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd0};
    drain();
    apb_access(1'b1, UNUSED_ADDR, 32'd7, rd);
    check_radix_readback();
    // Radix sixty-three saturates to thirty-six.
    set_radix(6'd63);
    value_queue = '{32'hFFFF_FFFF, 32'd35, 32'd36};
    drain();
    set_radix(6'd16);
    value_queue = '{32'hDEAD_BEEF, 32'h0ABC_DEF0};
    drain();
    set_radix(6'd36);
    value_queue = '{32'h7FFF_FFFF};
    drain();

    for (int k = 0; k < 12; k++) begin
      r = (k % 4 == 3) ? RADIX_W'($urandom_range(4, 35)) : phase_radix[k];
      if (k == 3) r = phase_radix[k];
      set_radix(r);
      base = (r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r;
      count = (base <= 3) ? 12 : 35;
      if (k == 11) calm = 1'b1;
      if (k == 0) hold_ordered++;
      for (int i = 0; i < count; i++) value_queue.push_back(pick_value(base));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && config_errors == 0 && expected_text.size() == 0) begin
      $display("integer_to_radix_ascii regression: pass");
    end else begin
      $display("integer_to_radix_ascii regression: fail");
    end
    $finish;
  end

endmodule
